// File: hdl/mwm_pkg.sv
package mwm_pkg;

    localparam int FRACTION_BITS_DEF = 13;

    localparam int KIND_W   = 2;
    localparam int DEMAND_W = 15;
    localparam int RADIUS_W = 16;
    localparam int SPEED_W  = 16;
    localparam int WHEEL_W  = 16;
    localparam int CFG_W    = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [KIND_W-1:0] KIND_STRAFE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CIRCLE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_STOP   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TRACK = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BASE  = 1'd1;

    localparam logic [CFG_W-1:0] CFG_RESET = 12'd200;

    // omega quotient bits; anything at or above 2^OMEGA_QW saturates
    localparam int OMEGA_QW = 14;
    localparam logic [OMEGA_QW-1:0] OMEGA_MAX = 14'd16383;

    // rounded wheel quotient never exceeds 2^17
    localparam int WHEEL_QW = 17;
    localparam logic [WHEEL_QW-1:0] OUT_MAX = 17'd32767;

endpackage

// File: hdl/mwm_if.sv
interface mwm_cmd_if import mwm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [KIND_W-1:0]          kind;
    logic signed [DEMAND_W-1:0] lateral;
    logic signed [DEMAND_W-1:0] forward;
    logic signed [DEMAND_W-1:0] turn;
    logic [RADIUS_W-1:0]        radius;
    logic                       turn_left;
    logic [SPEED_W-1:0]         speed_scale;

    modport source (output valid, kind, lateral, forward, turn, radius, turn_left,
                    speed_scale, input ready);
    modport sink   (input valid, kind, lateral, forward, turn, radius, turn_left,
                    speed_scale, output ready);
endinterface

interface mwm_res_if import mwm_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [WHEEL_W-1:0] front_left;
    logic signed [WHEEL_W-1:0] front_right;
    logic signed [WHEEL_W-1:0] rear_left;
    logic signed [WHEEL_W-1:0] rear_right;
    logic                      motion_on;

    modport source (output valid, front_left, front_right, rear_left, rear_right, motion_on,
                    input ready);
    modport sink   (input valid, front_left, front_right, rear_left, rear_right, motion_on,
                    output ready);
endinterface

interface mwm_cfg_if import mwm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/mwm_div.sv
// Restoring divider, one quotient bit per stage. Caller guarantees num < den << QW.
module mwm_div import mwm_pkg::*; #(
    parameter int NW = 32,
    parameter int DW = 16,
    parameter int QW = 16,
    parameter int SW = 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    input  logic [SW-1:0] i_side,
    output logic          o_valid,
    output logic [QW-1:0] o_quo,
    output logic [SW-1:0] o_side
);
    localparam int CW = (NW > DW + QW) ? NW : DW + QW;

    logic          r_vld  [QW];
    logic [NW-1:0] r_rem  [QW];
    logic [DW-1:0] r_den  [QW];
    logic [QW-1:0] r_q    [QW];
    logic [SW-1:0] r_side [QW];

    for (genvar s = 0; s < QW; s++) begin : g_st
        logic          w_vld;
        logic [NW-1:0] w_rem;
        logic [DW-1:0] w_den;
        logic [QW-1:0] w_q;
        logic [SW-1:0] w_side;
        logic [CW-1:0] w_sub;
        logic          w_ge;

        if (s == 0) begin : g_first
            assign w_vld  = i_valid;
            assign w_rem  = i_num;
            assign w_den  = i_den;
            assign w_q    = '0;
            assign w_side = i_side;
        end else begin : g_next
            assign w_vld  = r_vld[s-1];
            assign w_rem  = r_rem[s-1];
            assign w_den  = r_den[s-1];
            assign w_q    = r_q[s-1];
            assign w_side = r_side[s-1];
        end

        assign w_sub = CW'(w_den) << (QW - 1 - s);
        assign w_ge  = CW'(w_rem) >= w_sub;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[s] <= 1'b0;
            end else if (i_en) begin
                r_vld[s] <= w_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s]  <= w_ge ? NW'(CW'(w_rem) - w_sub) : w_rem;
                r_q[s]    <= w_ge ? (w_q | (QW'(1) << (QW - 1 - s))) : w_q;
                r_den[s]  <= w_den;
                r_side[s] <= w_side;
            end
        end
    end

    assign o_valid = r_vld[QW-1];
    assign o_quo   = r_q[QW-1];
    assign o_side  = r_side[QW-1];
endmodule

// File: hdl/mwm_front.sv
// Command capture, circle omega division, wheel mixing and the normalization divisor.
module mwm_front import mwm_pkg::*; #(
    parameter int F  = FRACTION_BITS_DEF,
    parameter int MB = (F + 1 > 16) ? F + 1 : 16
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  logic                       i_valid,
    input  logic [KIND_W-1:0]          i_kind,
    input  logic signed [DEMAND_W-1:0] i_lateral,
    input  logic signed [DEMAND_W-1:0] i_forward,
    input  logic signed [DEMAND_W-1:0] i_turn,
    input  logic [RADIUS_W-1:0]        i_radius,
    input  logic                       i_turn_left,
    input  logic [SPEED_W-1:0]         i_speed,
    input  logic [CFG_W-1:0]           i_track,
    input  logic [CFG_W-1:0]           i_base,
    output logic                       o_valid,
    output logic                       o_motion,
    output logic [SPEED_W-1:0]         o_speed,
    output logic signed [MB:0]         o_w   [4],
    output logic [MB-1:0]              o_mag [4],
    output logic [MB-1:0]              o_s
);
    localparam int WW  = MB + 1;
    localparam int ONW = CFG_W + 1 + F;
    localparam int ODW = RADIUS_W + 2;
    localparam int OCW = (ONW > ODW + OMEGA_QW) ? ONW : ODW + OMEGA_QW;
    localparam int SW  = KIND_W + 3 * DEMAND_W + 1 + SPEED_W + 1;
    localparam logic [MB-1:0] ONE = MB'(1) << F;

    // stage A: capture and saturation check
    logic                  r_a_vld;
    logic [ONW-1:0]        r_a_num;
    logic [ODW-1:0]        r_a_den;
    logic                  r_a_sat;
    logic [SW-1:0]         r_a_side;
    logic [ONW-1:0]        w_num;
    logic [ODW-1:0]        w_den;

    assign w_num = ONW'(({1'b0, i_track} + {1'b0, i_base})) << F;
    assign w_den = {i_radius, 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (i_en) begin
            r_a_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_sat  <= OCW'(w_num) >= (OCW'(w_den) << OMEGA_QW);
            r_a_num  <= w_num;
            r_a_den  <= w_den;
            r_a_side <= {i_kind, i_lateral, i_forward, i_turn, i_turn_left, i_speed, 1'b0};
        end
    end

    logic                  d_vld;
    logic [OMEGA_QW-1:0]   d_q;
    logic [SW-1:0]         d_side;
    logic [SW-1:0]         w_side_in;

    assign w_side_in = {r_a_side[SW-1:1], r_a_sat};

    mwm_div #(.NW(ONW), .DW(ODW), .QW(OMEGA_QW), .SW(SW)) u_omega (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (i_en),
        .i_valid (r_a_vld),
        .i_num   (r_a_sat ? '0 : r_a_num),
        .i_den   (r_a_den),
        .i_side  (w_side_in),
        .o_valid (d_vld),
        .o_quo   (d_q),
        .o_side  (d_side)
    );

    // stage B: wheel mix
    logic [KIND_W-1:0]          b_kind;
    logic signed [DEMAND_W-1:0] b_lat, b_fwd, b_trn;
    logic                       b_tl, b_sat;
    logic [SPEED_W-1:0]         b_speed;
    logic [OMEGA_QW-1:0]        b_om;
    logic signed [WW-1:0]       b_x, b_y, b_r;
    logic signed [WW-1:0]       b_w [4];

    assign {b_kind, b_lat, b_fwd, b_trn, b_tl, b_speed, b_sat} = d_side;
    assign b_om = b_sat ? OMEGA_MAX : d_q;

    always_comb begin
        if (b_kind == KIND_CIRCLE) begin
            b_x = b_tl ? WW'(ONE) : -WW'(ONE);
            b_y = '0;
            b_r = b_tl ? WW'(b_om) : -WW'(b_om);
        end else begin
            b_x = WW'(b_lat);
            b_y = WW'(b_fwd);
            b_r = WW'(b_trn);
        end
        b_w[0] = b_y + b_x - b_r;
        b_w[1] = b_y - b_x + b_r;
        b_w[2] = b_y - b_x - b_r;
        b_w[3] = b_y + b_x + b_r;
    end

    logic                 r_b_vld, r_b_mot;
    logic [SPEED_W-1:0]   r_b_speed;
    logic signed [WW-1:0] r_b_w   [4];
    logic [MB-1:0]        r_b_mag [4];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (i_en) begin
            r_b_vld <= d_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_b_mot   <= (b_kind == KIND_STRAFE) || (b_kind == KIND_CIRCLE);
            r_b_speed <= b_speed;
            for (int i = 0; i < 4; i++) begin
                r_b_w[i]   <= b_w[i];
                r_b_mag[i] <= MB'(b_w[i][WW-1] ? -b_w[i] : b_w[i]);
            end
        end
    end

    // stage C: pairwise maximum
    logic                 r_c_vld, r_c_mot;
    logic [SPEED_W-1:0]   r_c_speed;
    logic signed [WW-1:0] r_c_w   [4];
    logic [MB-1:0]        r_c_mag [4];
    logic [MB-1:0]        r_c_m01, r_c_m23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld <= 1'b0;
        end else if (i_en) begin
            r_c_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_c_mot   <= r_b_mot;
            r_c_speed <= r_b_speed;
            r_c_w     <= r_b_w;
            r_c_mag   <= r_b_mag;
            r_c_m01   <= (r_b_mag[0] > r_b_mag[1]) ? r_b_mag[0] : r_b_mag[1];
            r_c_m23   <= (r_b_mag[2] > r_b_mag[3]) ? r_b_mag[2] : r_b_mag[3];
        end
    end

    // stage D: divisor is at least one
    logic                 r_d_vld, r_d_mot;
    logic [SPEED_W-1:0]   r_d_speed;
    logic signed [WW-1:0] r_d_w   [4];
    logic [MB-1:0]        r_d_mag [4];
    logic [MB-1:0]        r_d_s;
    logic [MB-1:0]        d_m;

    assign d_m = (r_c_m01 > r_c_m23) ? r_c_m01 : r_c_m23;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld <= 1'b0;
        end else if (i_en) begin
            r_d_vld <= r_c_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_d_mot   <= r_c_mot;
            r_d_speed <= r_c_speed;
            r_d_w     <= r_c_w;
            r_d_mag   <= r_c_mag;
            r_d_s     <= (d_m > ONE) ? d_m : ONE;
        end
    end

    assign o_valid  = r_d_vld;
    assign o_motion = r_d_mot;
    assign o_speed  = r_d_speed;
    assign o_w      = r_d_w;
    assign o_mag    = r_d_mag;
    assign o_s      = r_d_s;
endmodule

// File: hdl/mecanum_wheel_mixer.sv
// Pipeline from command transaction to result: capture, 14-stage omega divider,
// 3 mix/max stages, 2 scale stages, 17-stage wheel divider, output register.
// Throughput: one command per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a downstream stall holds every stage in place.
// Reset (synchronous, active low) empties the pipeline and sets both geometry
// registers to 200 mm.
module mecanum_wheel_mixer import mwm_pkg::*; #(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    mwm_cmd_if.sink   i_cmd,
    mwm_cfg_if.sink   i_cfg,
    mwm_res_if.source o_res
);
    localparam int MB = (FRACTION_BITS + 1 > 16) ? FRACTION_BITS + 1 : 16;
    localparam int WW = MB + 1;
    localparam int AW = MB + SPEED_W;
    localparam int NW = AW + 2;
    localparam int DW = MB + 1;

    logic             w_en;
    logic             r_out_vld;
    logic [CFG_W-1:0] r_track, r_base;

    assign w_en        = !r_out_vld || o_res.ready;
    assign i_cmd.ready = w_en;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_track <= CFG_RESET;
            r_base  <= CFG_RESET;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                REG_TRACK: r_track <= i_cfg.data;
                REG_BASE:  r_base  <= i_cfg.data;
                default:   ;
            endcase
        end
    end

    logic                 f_vld, f_mot;
    logic [SPEED_W-1:0]   f_speed;
    logic signed [WW-1:0] f_w   [4];
    logic [MB-1:0]        f_mag [4];
    logic [MB-1:0]        f_s;

    mwm_front #(.F(FRACTION_BITS), .MB(MB)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (w_en),
        .i_valid     (i_cmd.valid),
        .i_kind      (i_cmd.kind),
        .i_lateral   (i_cmd.lateral),
        .i_forward   (i_cmd.forward),
        .i_turn      (i_cmd.turn),
        .i_radius    (i_cmd.radius),
        .i_turn_left (i_cmd.turn_left),
        .i_speed     (i_cmd.speed_scale),
        .i_track     (r_track),
        .i_base      (r_base),
        .o_valid     (f_vld),
        .o_motion    (f_mot),
        .o_speed     (f_speed),
        .o_w         (f_w),
        .o_mag       (f_mag),
        .o_s         (f_s)
    );

    // stage E: magnitude times speed
    logic          r_e_vld, r_e_mot;
    logic [AW-1:0] r_e_a   [4];
    logic          r_e_neg [4];
    logic [MB-1:0] r_e_s;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_en) begin
            r_e_vld <= f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_e_mot <= f_mot;
            r_e_s   <= f_s;
            for (int i = 0; i < 4; i++) begin
                r_e_a[i]   <= AW'(f_mag[i]) * AW'(f_speed);
                r_e_neg[i] <= f_w[i][WW-1];
            end
        end
    end

    // stage F: round-half-up numerator and doubled divisor
    logic          r_f_vld, r_f_mot;
    logic [NW-1:0] r_f_n   [4];
    logic          r_f_neg [4];
    logic [DW-1:0] r_f_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f_vld <= 1'b0;
        end else if (w_en) begin
            r_f_vld <= r_e_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_f_mot <= r_e_mot;
            r_f_neg <= r_e_neg;
            r_f_d   <= {r_e_s, 1'b0};
            for (int i = 0; i < 4; i++) begin
                r_f_n[i] <= {r_e_a[i], 1'b0} + NW'(r_e_s);
            end
        end
    end

    logic                g_vld [4];
    logic [WHEEL_QW-1:0] g_q   [4];
    logic [1:0]          g_side [4];

    for (genvar l = 0; l < 4; l++) begin : g_lane
        mwm_div #(.NW(NW), .DW(DW), .QW(WHEEL_QW), .SW(2)) u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (r_f_vld),
            .i_num   (r_f_n[l]),
            .i_den   (r_f_d),
            .i_side  ({r_f_mot, r_f_neg[l]}),
            .o_valid (g_vld[l]),
            .o_quo   (g_q[l]),
            .o_side  (g_side[l])
        );
    end

    // output register: clamp, sign, force zero on stop
    logic signed [WHEEL_W-1:0] r_out_w [4];
    logic                      r_out_mot;
    logic signed [WHEEL_W-1:0] g_w     [4];

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            logic [WHEEL_QW-1:0] v_c;
            v_c    = (g_q[i] > OUT_MAX) ? OUT_MAX : g_q[i];
            g_w[i] = !g_side[0][1] ? '0 :
                     g_side[i][0] ? -WHEEL_W'(v_c) : WHEEL_W'(v_c);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= g_vld[0] & g_vld[1] & g_vld[2] & g_vld[3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_w   <= g_w;
            r_out_mot <= g_side[0][1];
        end
    end

    assign o_res.valid       = r_out_vld;
    assign o_res.front_left  = r_out_w[0];
    assign o_res.front_right = r_out_w[1];
    assign o_res.rear_left   = r_out_w[2];
    assign o_res.rear_right  = r_out_w[3];
    assign o_res.motion_on   = r_out_mot;
endmodule

// File: hdl/mwm_chk.sv
module mwm_chk import mwm_pkg::*; (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_vld,
    input logic                      i_rdy,
    input logic signed [WHEEL_W-1:0] i_fl,
    input logic signed [WHEEL_W-1:0] i_fr,
    input logic signed [WHEEL_W-1:0] i_rl,
    input logic signed [WHEEL_W-1:0] i_rr,
    input logic                      i_mot
);
    localparam logic [WHEEL_W-1:0] MOST_NEG = {1'b1, {(WHEEL_W-1){1'b0}}};

    a_empty_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_vld)
        else $error("result valid right after reset");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld && !i_mot |-> i_fl == '0 && i_fr == '0 && i_rl == '0 && i_rr == '0)
        else $error("stop result carries nonzero wheel value");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld |-> i_fl != MOST_NEG && i_fr != MOST_NEG && i_rl != MOST_NEG
                  && i_rr != MOST_NEG)
        else $error("wheel value outside symmetric range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_vld && !i_rdy |=> i_vld && $stable(i_fl) && $stable(i_rr) && $stable(i_mot))
        else $error("stalled result transaction changed");
endmodule

bind mecanum_wheel_mixer mwm_chk u_mwm_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_vld   (o_res.valid),
    .i_rdy   (o_res.ready),
    .i_fl    (o_res.front_left),
    .i_fr    (o_res.front_right),
    .i_rl    (o_res.rear_left),
    .i_rr    (o_res.rear_right),
    .i_mot   (o_res.motion_on)
);
